FILE: hdl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  localparam int WINDOW_DEPTH    = 64;
  localparam int MAX_CHUNK_BYTES = 65536;

  localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // wide enough for the effective window length and for the 7-bit register
  localparam int WIN_LW = (WIN_AW + 1 > 7) ? WIN_AW + 1 : 7;
  localparam int CNT_W  = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int LEN_W  = 17;
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam int WORD_W      = 32;
  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int WLEN_W      = 7;
  localparam int REASON_W    = 2;
  localparam int DIV_STEP_W  = $clog2(WORD_W + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_PRIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_DIVISOR   = 3'd5;

  localparam logic [WORD_W-1:0] RST_HASH_PRIME    = 32'd3;
  localparam logic [WORD_W-1:0] RST_WINDOW_OUT    = 32'd1264544299;
  localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH = 7'd31;
  localparam logic [LEN_W-1:0]  RST_MIN_CHUNK     = 17'd2048;
  localparam logic [LEN_W-1:0]  RST_MAX_CHUNK     = 17'd16384;
  localparam logic [WORD_W-1:0] RST_AVG_DIVISOR   = 32'd4096;

  localparam logic [REASON_W-1:0] CUT_MATCH = 2'd0;
  localparam logic [REASON_W-1:0] CUT_MAX   = 2'd1;
  localparam logic [REASON_W-1:0] CUT_END   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_FP_LO,
    S_MUL_FP_HI,
    S_MUL_CS,
    S_MUL_OUT,
    S_SUB,
    S_CHECK,
    S_DIV,
    S_EMIT
  } rhc_state_t;

  function automatic logic [HASH_W-1:0] sext_byte64(input logic [BYTE_W-1:0] b);
    return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  function automatic logic [WORD_W-1:0] sext_byte32(input logic [BYTE_W-1:0] b);
    return {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rhc_mul.sv
`default_nettype none

module rhc_mul (
  input  wire logic                          clk,
  input  wire logic [rhc_pkg::WORD_W-1:0]    a,
  input  wire logic [rhc_pkg::WORD_W-1:0]    b,
  output logic      [2*rhc_pkg::WORD_W-1:0]  p
);
  import rhc_pkg::*;

  always_ff @(posedge clk) begin
    p <= (2*WORD_W)'(a) * (2*WORD_W)'(b);
  end

endmodule

`default_nettype wire

FILE: hdl/rhc_rem.sv
`default_nettype none

module rhc_rem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rhc_pkg::WORD_W-1:0]  dividend,
  input  wire logic [rhc_pkg::WORD_W-1:0]  divisor,
  output logic                             done,
  output logic      [rhc_pkg::WORD_W-1:0]  remainder
);
  import rhc_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] steps;
  logic [WORD_W-1:0]     dvd;
  logic [WORD_W-1:0]     dsr;
  logic [WORD_W:0]       trial;
  logic                  fits;

  assign trial = {remainder, dvd[WORD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_STEP_W'(WORD_W);
      end else if (busy) begin
        steps <= steps - DIV_STEP_W'(1);
        if (steps == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring step; a zero divisor leaves the dividend as remainder
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      if (fits) begin
        remainder <= WORD_W'(trial - {1'b0, dsr});
      end else begin
        remainder <= trial[WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rolling_hash_chunker_core.sv
`default_nettype none

// Channel   Direction  Signals
// input     in         in_valid, in_ready, command, data_byte
// result    out        out_valid, out_ready, chunk_length, chunk_fingerprint, cut_reason
// config    in         cfg_write, cfg_index, cfg_data
//
// When the chunk is below min_chunk, a data byte goes from acceptance back to
// idle through four products on the shared 32x32 multiplier, a subtract and
// the cut check. Past min_chunk the remainder test runs on the bit-serial
// divider, unless max_chunk or the cap forces a cut; a cut loads the result register.
// A flush loads the result register, unless it follows a cut with no byte since.
// Reset clears the window valid bits, hashes, counters and configuration registers at once.
// A result waits in the output register; the block stalls only when a new result
// is ready and the previous one has not been taken.

module rolling_hash_chunker_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic [rhc_pkg::BYTE_W-1:0]       data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [rhc_pkg::LEN_W-1:0]        chunk_length,
  output logic      [rhc_pkg::HASH_W-1:0]       chunk_fingerprint,
  output logic      [rhc_pkg::REASON_W-1:0]     cut_reason,
  input  wire logic                             cfg_write,
  input  wire logic [rhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rhc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rhc_pkg::*;

  rhc_state_t state, state_next;

  logic [WORD_W-1:0] hash_prime;
  logic [WORD_W-1:0] window_out_factor;
  logic [WLEN_W-1:0] window_length;
  logic [LEN_W-1:0]  min_chunk;
  logic [LEN_W-1:0]  max_chunk;
  logic [WORD_W-1:0] avg_divisor;

  logic [BYTE_W-1:0]   window_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_vld;
  logic [BYTE_W-1:0]   win_rd;
  logic                win_rd_vld;
  logic [WIN_AW-1:0]   win_pos;
  logic [WIN_LW-1:0]   eff_len;
  logic [WIN_LW-1:0]   pos_inc;
  logic [WIN_AW-1:0]   pos_next;
  logic [BYTE_W-1:0]   oldest;

  logic [HASH_W-1:0]   chunk_hash;
  logic [WORD_W-1:0]   window_checksum;
  logic [CNT_W-1:0]    chunk_count;
  logic                stream_had_bytes;

  logic [BYTE_W-1:0]   byte_q;
  logic [HASH_W-1:0]   hash_acc;
  logic [WORD_W-1:0]   cs_acc;
  logic [REASON_W-1:0] reason_q;

  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [2*WORD_W-1:0] mul_p;

  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_rem;

  logic accept;
  logic slot_free;
  logic emit_load;
  logic flush_emit;
  logic at_cap;
  logic past_min;
  logic at_max;
  logic rem_hit;

  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign flush_emit = !stream_had_bytes || (chunk_count != '0);
  assign at_cap     = chunk_count >= CNT_W'(MAX_CHUNK_BYTES);
  assign past_min   = CMP_W'(chunk_count) >= CMP_W'(min_chunk);
  assign at_max     = CMP_W'(chunk_count) == CMP_W'(max_chunk);
  assign rem_hit    = div_rem == hash_prime;

  assign eff_len  = ((window_length == '0) ||
                     (WIN_LW'(window_length) > WIN_LW'(WINDOW_DEPTH))) ?
                    WIN_LW'(WINDOW_DEPTH) : WIN_LW'(window_length);
  assign pos_inc  = WIN_LW'(win_pos) + WIN_LW'(1);
  assign pos_next = (pos_inc >= eff_len) ? '0 : WIN_AW'(pos_inc);
  assign oldest   = win_rd_vld ? win_rd : '0;

  rhc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rhc_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (window_checksum),
    .divisor   (avg_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command) begin
            state_next = flush_emit ? S_EMIT : S_IDLE;
          end else begin
            state_next = S_MUL_FP_LO;
          end
        end
      end
      S_MUL_FP_LO: state_next = S_MUL_FP_HI;
      S_MUL_FP_HI: state_next = S_MUL_CS;
      S_MUL_CS:    state_next = S_MUL_OUT;
      S_MUL_OUT:   state_next = S_SUB;
      S_SUB:       state_next = S_CHECK;
      S_CHECK: begin
        priority if (at_cap || (past_min && at_max)) begin
          state_next = S_EMIT;
        end else if (past_min) begin
          state_next = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = rem_hit ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = hash_prime;
    div_start = 1'b0;
    emit_load = 1'b0;
    unique case (state)
      S_IDLE:      in_ready = 1'b1;
      S_MUL_FP_LO: mul_a = chunk_hash[WORD_W-1:0];
      S_MUL_FP_HI: mul_a = chunk_hash[HASH_W-1:WORD_W];
      S_MUL_CS:    mul_a = window_checksum;
      S_MUL_OUT: begin
        mul_a = sext_byte32(oldest);
        mul_b = window_out_factor;
      end
      S_SUB:       ;
      S_CHECK:     div_start = past_min && !at_cap && !at_max;
      S_DIV:       ;
      S_EMIT:      emit_load = slot_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      hash_prime        <= RST_HASH_PRIME;
      window_out_factor <= RST_WINDOW_OUT;
      window_length     <= RST_WINDOW_LENGTH;
      min_chunk         <= RST_MIN_CHUNK;
      max_chunk         <= RST_MAX_CHUNK;
      avg_divisor       <= RST_AVG_DIVISOR;
      chunk_hash        <= '0;
      window_checksum   <= '0;
      chunk_count       <= '0;
      stream_had_bytes  <= 1'b0;
      win_pos           <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_HASH_PRIME:    hash_prime        <= cfg_data[WORD_W-1:0];
          REG_WINDOW_OUT:    window_out_factor <= cfg_data[WORD_W-1:0];
          REG_WINDOW_LENGTH: window_length     <= cfg_data[WLEN_W-1:0];
          REG_MIN_CHUNK:     min_chunk         <= cfg_data[LEN_W-1:0];
          REG_MAX_CHUNK:     max_chunk         <= cfg_data[LEN_W-1:0];
          REG_AVG_DIVISOR:   avg_divisor       <= cfg_data[WORD_W-1:0];
          default:           ;
        endcase
      end

      // flush right after an exact cut: drop, nothing to emit
      if (accept && command && !flush_emit) begin
        stream_had_bytes <= 1'b0;
        chunk_hash       <= '0;
      end

      if (state == S_SUB) begin
        chunk_hash       <= hash_acc;
        window_checksum  <= cs_acc - mul_p[WORD_W-1:0];
        chunk_count      <= chunk_count + CNT_W'(1);
        stream_had_bytes <= 1'b1;
        win_pos          <= pos_next;
      end

      if (emit_load) begin
        out_valid   <= 1'b1;
        chunk_count <= '0;
        chunk_hash  <= '0;
        if (reason_q == CUT_END) begin
          stream_had_bytes <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld    <= '0;
      win_rd_vld <= 1'b0;
    end else begin
      win_rd_vld <= win_vld[win_pos];
      if (state == S_SUB) begin
        win_vld[win_pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_rd <= window_mem[win_pos];
    if (state == S_SUB) begin
      window_mem[win_pos] <= byte_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= data_byte;
      if (command) begin
        reason_q <= CUT_END;
      end
    end
    unique case (state)
      S_MUL_FP_HI: hash_acc <= mul_p + sext_byte64(byte_q);
      S_MUL_CS:    hash_acc <= hash_acc + {mul_p[WORD_W-1:0], {WORD_W{1'b0}}};
      S_MUL_OUT:   cs_acc   <= mul_p[WORD_W-1:0] + sext_byte32(byte_q);
      S_CHECK:     reason_q <= CUT_MAX;
      S_DIV:       reason_q <= CUT_MATCH;
      default:     ;
    endcase
    if (emit_load) begin
      chunk_length      <= LEN_W'(chunk_count);
      chunk_fingerprint <= chunk_hash;
      cut_reason        <= reason_q;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    chunk_count <= CNT_W'(MAX_CHUNK_BYTES))
    else $error("chunk length above cap");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside remainder test");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (WIN_LW'(win_pos) < eff_len))
    else $error("window position beyond window length");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (out_valid && (chunk_count == '0) && (chunk_hash == '0)))
    else $error("emitted chunk not cleared");

endmodule

`default_nettype wire
